>>> rtl/wftc_pkg.sv
// types, constants and classification function for the frame type counter
package wftc_pkg;

   localparam int CNT_NUM     = 6;
   localparam int CNT_W       = 32;
   localparam int CHAN_W      = 4;
   localparam int DWELL_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int SLOT_W      = 3;

   // counter slots
   localparam logic [SLOT_W-1:0] SLOT_TOTAL  = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_BEACON = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_PROBE  = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_DEAUTH = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_DATA   = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_OTHER  = 3'd5;

   // frame control type and subtype codes
   localparam logic [1:0] TYPE_MGMT          = 2'h0;
   localparam logic [1:0] TYPE_DATA          = 2'h2;
   localparam logic [3:0] SUBTYPE_BEACON     = 4'h8;
   localparam logic [3:0] SUBTYPE_PROBE_REQ  = 4'h4;
   localparam logic [3:0] SUBTYPE_PROBE_RESP = 4'h5;
   localparam logic [3:0] SUBTYPE_DEAUTH     = 4'hC;

   localparam logic [11:0] MIN_FRAME_LEN = 12'd2;

   // reset values of the registers
   localparam logic [CHAN_W-1:0]  FIRST_CHAN_RST = 4'd1;
   localparam logic [CHAN_W-1:0]  LAST_CHAN_RST  = 4'd13;
   localparam logic [DWELL_W-1:0] DWELL_RST      = 16'd500;

   typedef enum logic [1:0] {
      CMD_FRAME = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_SHORT = 2'd2,
      CMD_LONG  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_CHAN = 2'd0,
      CSR_LAST_CHAN  = 2'd1,
      CSR_DWELL      = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  frame_control;
      logic [11:0] frame_length;
      logic        is_misc;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0]  total_count;
      logic [CNT_W-1:0]  beacon_count;
      logic [CNT_W-1:0]  probe_count;
      logic [CNT_W-1:0]  deauth_count;
      logic [CNT_W-1:0]  data_frame_count;
      logic [CNT_W-1:0]  other_count;
      logic [CHAN_W-1:0] channel;
      logic              hop_on;
      logic              channel_changed;
   } rsp_type;

   function automatic logic [SLOT_W-1:0] classify(input logic [7:0] fc);
      logic [1:0]        ftype;
      logic [3:0]        sub;
      logic [SLOT_W-1:0] slot;
      ftype = fc[3:2];
      sub   = fc[7:4];
      slot  = SLOT_OTHER;
      if (ftype == TYPE_MGMT) begin
         if (sub == SUBTYPE_BEACON) begin
            slot = SLOT_BEACON;
         end else if (sub == SUBTYPE_PROBE_REQ || sub == SUBTYPE_PROBE_RESP) begin
            slot = SLOT_PROBE;
         end else if (sub == SUBTYPE_DEAUTH) begin
            slot = SLOT_DEAUTH;
         end
      end else if (ftype == TYPE_DATA) begin
         slot = SLOT_DATA;
      end
      return slot;
   endfunction

endpackage

>>> rtl/wifi_frame_type_counter_with_hop.sv
// frame type statistics counter with dwell based channel hopping
//
// Usage: each request on req_payload is one event (received frame, 1 ms tick,
// short press or long press). Every request gives exactly one result on
// rsp_payload: all six frame counters, the current channel, the hop enable
// and a flag set when this request moved the channel.
// A request is taken when req_valid is high and req_stall is low; a result is
// taken when rsp_valid is high and rsp_stall is low.
// Results are registered in the output entry, or in the skid entry if occupied.
// Throughput: one request per cycle while req_stall is low; the counter, dwell
// and channel update is a single pass of logic into the state registers.
// A two-entry result buffer (output register plus skid register) lets the
// block take requests while a result waits; req_stall rises only when both
// entries hold results the receiver has not taken.
// The csr_ port writes first channel, last channel and dwell length; write it
// only while the block is idle. Writes never move the current channel.
// Reset (synchronous): counters clear, channel 1, hopping on, dwell count 0,
// registers return to 1, 13 and 500, and both result entries empty.
module wifi_frame_type_counter_with_hop
   import wftc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CHAN_W-1:0]  first_chan_ff;
   logic [CHAN_W-1:0]  last_chan_ff;
   logic [DWELL_W-1:0] dwell_ff;

   logic [CNT_W-1:0]   cnt_ff [CNT_NUM];
   logic [CNT_W-1:0]   cnt_in [CNT_NUM];
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic               hop_ff, hop_in;
   logic [DWELL_W-1:0] elapsed_ff, elapsed_in;

   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_type            skid_ff, skid_in;

   logic               req_fire;
   logic               rsp_fire;
   logic [CHAN_W-1:0]  chan_step;
   logic [DWELL_W-1:0] elapsed_inc;
   logic [SLOT_W-1:0]  slot;
   rsp_type            result;

   assign req_stall   = skid_valid_ff;
   assign req_fire    = req_valid && !skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign rsp_fire    = out_valid_ff && !rsp_stall;

   assign chan_step   = (chan_ff >= last_chan_ff) ? first_chan_ff : chan_ff + 4'd1;
   assign elapsed_inc = (elapsed_ff == {DWELL_W{1'b1}}) ? elapsed_ff : elapsed_ff + 16'd1;
   assign slot        = classify(req_payload.frame_control);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_chan_ff <= FIRST_CHAN_RST;
         last_chan_ff  <= LAST_CHAN_RST;
         dwell_ff      <= DWELL_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FIRST_CHAN: first_chan_ff <= csr_wdata[CHAN_W-1:0];
            CSR_LAST_CHAN:  last_chan_ff  <= csr_wdata[CHAN_W-1:0];
            CSR_DWELL:      dwell_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // event processing
   always_comb begin
      for (int i = 0; i < CNT_NUM; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      chan_in    = chan_ff;
      hop_in     = hop_ff;
      elapsed_in = elapsed_ff;
      if (req_fire) begin
         case (req_payload.command)
            CMD_FRAME: begin
               if (!req_payload.is_misc && req_payload.frame_length >= MIN_FRAME_LEN) begin
                  cnt_in[SLOT_TOTAL] = cnt_ff[SLOT_TOTAL] + 32'd1;
                  cnt_in[slot]       = cnt_ff[slot] + 32'd1;
               end
            end
            CMD_TICK: begin
               elapsed_in = elapsed_inc;
               if (hop_ff && elapsed_inc >= dwell_ff) begin
                  chan_in    = chan_step;
                  elapsed_in = '0;
               end
            end
            CMD_SHORT: begin
               if (hop_ff) begin
                  hop_in = 1'b0;
               end else begin
                  chan_in = chan_step;
               end
            end
            CMD_LONG: begin
               for (int i = 0; i < CNT_NUM; i++) begin
                  cnt_in[i] = '0;
               end
               hop_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.total_count      = cnt_in[SLOT_TOTAL];
      result.beacon_count     = cnt_in[SLOT_BEACON];
      result.probe_count      = cnt_in[SLOT_PROBE];
      result.deauth_count     = cnt_in[SLOT_DEAUTH];
      result.data_frame_count = cnt_in[SLOT_DATA];
      result.other_count      = cnt_in[SLOT_OTHER];
      result.channel          = chan_in;
      result.hop_on           = hop_in;
      result.channel_changed  = (chan_in != chan_ff);
   end

   // two-entry result buffer
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_fire) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CNT_NUM; i++) begin
            cnt_ff[i] <= '0;
         end
         chan_ff       <= FIRST_CHAN_RST;
         hop_ff        <= 1'b1;
         elapsed_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < CNT_NUM; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         chan_ff       <= chan_in;
         hop_ff        <= hop_in;
         elapsed_ff    <= elapsed_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // skid entry is only used behind a waiting output entry
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output entry");

   // long press clears counters (total, other checked) and turns hopping on
   a_long_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.command == CMD_LONG) |=>
         (cnt_ff[SLOT_TOTAL] == '0 && cnt_ff[SLOT_OTHER] == '0 && hop_ff))
      else $error("long press did not clear counters");

   // short press while hopping only locks the channel
   a_short_locks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.command == CMD_SHORT && hop_ff) |=>
         (!hop_ff && $stable(chan_ff)))
      else $error("short press while hopping moved the channel");

   // a request taken with the output free lands in the output entry
   a_result_next: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (!out_valid_ff || rsp_fire)) |=> out_valid_ff)
      else $error("result missing one cycle after request");

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the frame type counter with channel hopping
`timescale 1ns / 100ps

module testbench
   import wftc_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 1000;
   localparam int REPORT_MAX  = 100;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   req_type               req_payload  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   wifi_frame_type_counter_with_hop uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // predictor state and register copies
   logic [CNT_W-1:0]   counts [CNT_NUM];
   logic [CHAN_W-1:0]  chan_now;
   logic               hop_model;
   logic [DWELL_W-1:0] dwell_count;
   logic [CHAN_W-1:0]  cfg_first;
   logic [CHAN_W-1:0]  cfg_last;
   logic [DWELL_W-1:0] cfg_dwell;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      errors      = 0;
   int      idle_rate   = 0;
   int      gap_left    = 0;
   int      stall_left  = 0;
   int      quiet_count = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [CHAN_W-1:0] hop_target();
      return (chan_now >= cfg_last) ? cfg_first : chan_now + 4'd1;
   endfunction

   function automatic rsp_type predict_event(req_type r);
      rsp_type           res;
      logic [CHAN_W-1:0] prior;
      logic [SLOT_W-1:0] slot;
      prior = chan_now;
      case (cmd_type'(r.command))
         CMD_FRAME: begin
            if (!r.is_misc && r.frame_length >= MIN_FRAME_LEN) begin
               if (r.frame_control[3:2] == TYPE_DATA) begin
                  slot = SLOT_DATA;
               end else if (r.frame_control[3:2] != TYPE_MGMT) begin
                  slot = SLOT_OTHER;
               end else begin
                  case (r.frame_control[7:4])
                     SUBTYPE_BEACON:                        slot = SLOT_BEACON;
                     SUBTYPE_PROBE_REQ, SUBTYPE_PROBE_RESP: slot = SLOT_PROBE;
                     SUBTYPE_DEAUTH:                        slot = SLOT_DEAUTH;
                     default:                               slot = SLOT_OTHER;
                  endcase
               end
               counts[SLOT_TOTAL] = counts[SLOT_TOTAL] + 32'd1;
               counts[slot]       = counts[slot] + 32'd1;
            end
         end
         CMD_TICK: begin
            if (dwell_count != '1) begin
               dwell_count = dwell_count + 16'd1;
            end
            if (hop_model && dwell_count >= cfg_dwell) begin
               chan_now    = hop_target();
               dwell_count = '0;
            end
         end
         CMD_SHORT: begin
            if (hop_model) begin
               hop_model = 1'b0;
            end else begin
               chan_now = hop_target();
            end
         end
         default: begin
            for (int i = 0; i < CNT_NUM; i++) counts[i] = '0;
            hop_model = 1'b1;
         end
      endcase
      res.total_count      = counts[SLOT_TOTAL];
      res.beacon_count     = counts[SLOT_BEACON];
      res.probe_count      = counts[SLOT_PROBE];
      res.deauth_count     = counts[SLOT_DEAUTH];
      res.data_frame_count = counts[SLOT_DATA];
      res.other_count      = counts[SLOT_OTHER];
      res.channel          = chan_now;
      res.hop_on           = hop_model;
      res.channel_changed  = (chan_now != prior);
      return res;
   endfunction

   function automatic req_type make_req(cmd_type cmd, logic [7:0] fc,
                                        logic [11:0] len, logic misc);
      req_type r;
      r.command       = cmd;
      r.frame_control = fc;
      r.frame_length  = len;
      r.is_misc       = misc;
      return r;
   endfunction

   function automatic req_type random_event();
      req_type r;
      int      pick;
      r.frame_control = 8'($urandom_range(0, 255));
      r.frame_length  = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 3))
                                                     : 12'($urandom_range(0, 4095));
      r.is_misc       = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         r.command = CMD_FRAME;
         // bias toward the management subtypes that have their own counter
         if ($urandom_range(0, 1) == 0) begin
            r.frame_control[3:2] = TYPE_MGMT;
            case ($urandom_range(0, 3))
               0: r.frame_control[7:4] = SUBTYPE_BEACON;
               1: r.frame_control[7:4] = SUBTYPE_PROBE_REQ;
               2: r.frame_control[7:4] = SUBTYPE_PROBE_RESP;
               default: r.frame_control[7:4] = SUBTYPE_DEAUTH;
            endcase
         end
      end else if (pick < 85) begin
         r.command = CMD_TICK;
      end else if (pick < 95) begin
         r.command = CMD_SHORT;
      end else begin
         r.command = CMD_LONG;
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [CNT_W-1:0] exp_val,
                                       logic [CNT_W-1:0] act_val);
      if (act_val !== exp_val) begin
         errors++;
         if (errors <= REPORT_MAX) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
         end
      end
   endfunction

   // driver
   always @(posedge clock) begin
      logic valid_n;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_event(req_payload));
         end
         if (!req_valid || !req_stall) begin
            valid_n = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() != 0) begin
               if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
                  gap_left = $urandom_range(0, 3);
               end else begin
                  req_payload <= pending_reqs.pop_front();
                  valid_n = 1'b1;
               end
            end
            req_valid <= valid_n;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_rsp;
      logic    stall_n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, actual %p", $time, rsp_payload);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               check_field("total_count", exp_rsp.total_count, rsp_payload.total_count);
               check_field("beacon_count", exp_rsp.beacon_count, rsp_payload.beacon_count);
               check_field("probe_count", exp_rsp.probe_count, rsp_payload.probe_count);
               check_field("deauth_count", exp_rsp.deauth_count, rsp_payload.deauth_count);
               check_field("data_frame_count", exp_rsp.data_frame_count,
                           rsp_payload.data_frame_count);
               check_field("other_count", exp_rsp.other_count, rsp_payload.other_count);
               check_field("channel", CNT_W'(exp_rsp.channel),
                           CNT_W'(rsp_payload.channel));
               check_field("hop_on", CNT_W'(exp_rsp.hop_on), CNT_W'(rsp_payload.hop_on));
               check_field("channel_changed", CNT_W'(exp_rsp.channel_changed),
                           CNT_W'(rsp_payload.channel_changed));
            end
         end
         stall_n = 1'b0;
         if (stall_left > 0) begin
            stall_left--;
            stall_n = 1'b1;
         end else if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
            stall_left = $urandom_range(0, 3);
            stall_n = 1'b1;
         end
         rsp_stall <= stall_n;
      end
   end

   // watchdog on cycles with no request or result taken
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
         if (quiet_count >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_FIRST_CHAN: cfg_first = value[CHAN_W-1:0];
         CSR_LAST_CHAN:  cfg_last  = value[CHAN_W-1:0];
         CSR_DWELL:      cfg_dwell = value;
         default: ;
      endcase
   endtask

   // channel registers get random upper bits, which the block must drop
   task automatic set_config(logic [CHAN_W-1:0] first, logic [CHAN_W-1:0] last,
                             logic [DWELL_W-1:0] dwell);
      write_reg(CSR_FIRST_CHAN, {12'($urandom_range(0, 4095)), first});
      write_reg(CSR_LAST_CHAN, {12'($urandom_range(0, 4095)), last});
      write_reg(CSR_DWELL, dwell);
      write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)));
   endtask

   task automatic run_random(int n, int rate);
      idle_rate = rate;
      repeat (n) pending_reqs.push_back(random_event());
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < CNT_NUM; i++) counts[i] = '0;
      chan_now    = FIRST_CHAN_RST;
      hop_model   = 1'b1;
      dwell_count = '0;
      cfg_first   = FIRST_CHAN_RST;
      cfg_last    = LAST_CHAN_RST;
      cfg_dwell   = DWELL_RST;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every frame class, dropped frames, presses
      idle_rate = 2;
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h80, 12'd2, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h40, 12'hFFF, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h53, 12'd100, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'hC0, 12'd30, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h08, 12'd60, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'hFB, 12'd2, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h00, 12'd24, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h94, 12'd14, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h0C, 12'd8, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'hFF, 12'hAAA, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h80, 12'd100, 1'b1));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h80, 12'd0, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h80, 12'd1, 1'b0));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h08, 12'hFFF, 1'b1));
      pending_reqs.push_back(make_req(CMD_TICK, 8'hFF, 12'hFFF, 1'b1));
      pending_reqs.push_back(make_req(CMD_SHORT, 8'h80, 12'd50, 1'b0));
      pending_reqs.push_back(make_req(CMD_TICK, 8'h00, 12'd0, 1'b0));
      pending_reqs.push_back(make_req(CMD_SHORT, 8'h00, 12'd0, 1'b0));
      pending_reqs.push_back(make_req(CMD_SHORT, 8'hFF, 12'hFFF, 1'b1));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'hC8, 12'd40, 1'b0));
      pending_reqs.push_back(make_req(CMD_LONG, 8'h55, 12'h555, 1'b1));
      pending_reqs.push_back(make_req(CMD_FRAME, 8'h50, 12'd40, 1'b0));
      pending_reqs.push_back(make_req(CMD_TICK, 8'hAA, 12'hAAA, 1'b0));
      wait_drained();

      run_random(60, 3);
      set_config(4'd1, 4'd14, 16'd1);
      run_random(150, 2);
      set_config(4'd3, 4'd5, 16'd2);
      run_random(150, 0);
      // dwell zero and channel codes outside the normal band
      set_config(4'd0, 4'd15, 16'd0);
      run_random(120, 3);
      // first above last
      set_config(4'd15, 4'd0, 16'd1);
      run_random(100, 1);
      set_config(4'd9, 4'd2, 16'd3);
      run_random(100, 2);
      set_config(4'd1, 4'd14, 16'hFFFF);
      run_random(80, 2);
      set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 16'($urandom_range(0, 6)));
      run_random(120, 0);

      // dwell count runs past the dwell with hopping off, then a hop right after re-enable
      idle_rate = 0;
      set_config(4'd1, 4'd13, 16'd8);
      @(negedge clock);
      if (hop_model) begin
         pending_reqs.push_back(make_req(CMD_SHORT, 8'h00, 12'd0, 1'b0));
      end
      repeat (24) begin
         pending_reqs.push_back(make_req(CMD_TICK, 8'($urandom_range(0, 255)),
                                         12'($urandom_range(0, 4095)), 1'b0));
      end
      pending_reqs.push_back(make_req(CMD_LONG, 8'h00, 12'd0, 1'b0));
      pending_reqs.push_back(make_req(CMD_TICK, 8'h00, 12'd0, 1'b0));
      pending_reqs.push_back(make_req(CMD_TICK, 8'h00, 12'd0, 1'b0));
      wait_drained();
      repeat (5) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, expected_rsps.size());
      end
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
